### rtl/wdla_pkg.sv
// Package for the wheel delta line accumulator: widths, register indexes,
// state and unit codes shared by the core and its serial arithmetic unit.
// No dependencies.
package wdla_pkg;

    localparam int unsigned WIN_W       = 16;
    localparam int unsigned DELTA_W     = 16;
    localparam int unsigned PAGE_W      = 10;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned LINES_W     = 20;
    localparam int unsigned ACC_W       = 17;
    localparam int unsigned SUM_W       = 18;
    localparam int unsigned RATE_W      = 10;
    localparam int unsigned LINE_MAG_W  = 21;
    localparam int unsigned NUM_W       = 28;
    localparam int unsigned NOTCH_UNITS = 120;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned NOTCH_W     = 8;

    // one shift step per operand bit
    localparam int unsigned UNIT_STEPS = NUM_W;
    localparam int unsigned CNT_W      = $clog2(UNIT_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(UNIT_STEPS - 1);

    localparam logic [NOTCH_W-1:0] RST_LINES_VERT   = NOTCH_W'(3);
    localparam logic [NOTCH_W-1:0] RST_CHARS_HORIZ  = NOTCH_W'(3);
    localparam logic [TIME_W-1:0]  RST_IDLE_TIMEOUT = TIME_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINES_VERT   = 3'd0,
        CFG_CHARS_HORIZ  = 3'd1,
        CFG_PAGE_MODE    = 3'd2,
        CFG_IDLE_TIMEOUT = 3'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_RATE,
        ST_DIV_NOTCH,
        ST_MUL_NOTCH,
        ST_DIV_RATE,
        ST_FINISH
    } t_state;

endpackage

### rtl/wdla_serial_unit.sv
// Bit-serial multiply / restoring divide unit, one operand bit per cycle.
// Depends on wdla_pkg.
module wdla_serial_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wdla_pkg::t_unit_ctl       i_ctl,
    input  logic [wdla_pkg::NUM_W-1:0]  i_operand,
    input  logic [wdla_pkg::RATE_W-1:0] i_factor,
    output wdla_pkg::t_unit_sts       o_sts,
    output logic [wdla_pkg::NUM_W-1:0]  o_result
);
    import wdla_pkg::*;

    localparam int unsigned WORK_W = NUM_W + RATE_W;

    logic [WORK_W-1:0] r_work, n_work;
    logic [RATE_W-1:0] r_b, n_b;
    t_unit_op          r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [RATE_W:0]   mul_sum;
    logic [RATE_W+1:0] trial;
    logic              fits;

    always_comb begin
        // multiply: add factor into the upper part, then shift right
        mul_sum = {1'b0, r_work[WORK_W-1:NUM_W]}
                + (r_work[0] ? {1'b0, r_b} : {(RATE_W+1){1'b0}});
        // divide: shift the next dividend bit into the remainder and try
        trial = {1'b0, r_work[WORK_W-1:NUM_W], r_work[NUM_W-1]} - {2'b00, r_b};
        fits  = !trial[RATE_W+1];

        n_work = r_work;
        n_b    = r_b;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;

        if (i_ctl.start) begin
            n_work = {{RATE_W{1'b0}}, i_operand};
            n_b    = i_factor;
            n_op   = i_ctl.op;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: n_work = {mul_sum, r_work[NUM_W-1:1]};
                OP_DIV: begin
                    n_work = {fits ? trial[RATE_W-1:0]
                                   : {r_work[WORK_W-2:NUM_W], r_work[NUM_W-1]},
                              r_work[NUM_W-2:0], fits};
                end
                default: n_work = r_work;
            endcase
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_b    <= n_b;
        r_op   <= n_op;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = r_work[NUM_W-1:0];

endmodule

### rtl/wheel_delta_line_accumulator_core.sv
// Wheel delta line accumulator: top level with controller, axis state and
// configuration registers. Depends on wdla_pkg and wdla_serial_unit.
//
//  Channel   Signals                                   Direction
//  request   i_req_valid / o_req_ready + input fields  in
//  result    o_res_valid / i_res_ready + o_scroll_lines out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data           in, write only
//
// From acceptance to a valid result a request goes through a setup state,
// four passes through the shared bit-serial unit (multiply by rate, divide
// by 120, multiply by 120, divide by rate) and a write-back state; a zero
// rate skips the unit and goes from setup straight to write-back.
// A new request is taken the cycle after the result is registered.
// Synchronous active-low reset restores the register defaults and clears
// both accumulators, last times and the stored window id.
// A stalled result holds the core in write-back until the output slot frees.
module wheel_delta_line_accumulator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wdla_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wdla_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic [wdla_pkg::WIN_W-1:0]          i_window_id,
    input  logic signed [wdla_pkg::DELTA_W-1:0] i_wheel_delta,
    input  logic [wdla_pkg::PAGE_W-1:0]         i_page_size,
    input  logic                                i_axis_vertical,
    input  logic [wdla_pkg::TIME_W-1:0]         i_time_ms,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic signed [wdla_pkg::LINES_W-1:0] o_scroll_lines
);
    import wdla_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [NOTCH_W-1:0] r_lines_v, n_lines_v;
    logic [NOTCH_W-1:0] r_chars_h, n_chars_h;
    logic               r_page_mode, n_page_mode;
    logic [TIME_W-1:0]  r_timeout, n_timeout;

    // per-axis state and the last window id
    logic [WIN_W-1:0]  r_prev_win, n_prev_win;
    logic [TIME_W-1:0] r_last [2];
    logic [TIME_W-1:0] n_last [2];
    logic [ACC_W-1:0]  r_acc [2];
    logic [ACC_W-1:0]  n_acc [2];

    // captured request and working values
    logic [WIN_W-1:0]      r_win, n_win;
    logic [DELTA_W-1:0]    r_delta, n_delta;
    logic [PAGE_W-1:0]     r_page, n_page;
    logic                  r_ax, n_ax;
    logic [TIME_W-1:0]     r_time, n_time;
    logic [SUM_W-1:0]      r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [RATE_W-1:0]     r_rate, n_rate;
    logic [LINE_MAG_W-1:0] r_lines, n_lines;
    logic [SUM_W-1:0]      r_rem, n_rem;

    logic               r_out_valid, n_out_valid;
    logic [LINES_W-1:0] r_out_lines, n_out_lines;

    // setup and write-back terms
    logic [PAGE_W-1:0]  page_eff;
    logic [NOTCH_W-1:0] reg_rate;
    logic [RATE_W-1:0]  rate;
    logic               win_change;
    logic [ACC_W-1:0]   acc_old;
    logic [TIME_W-1:0]  idle_gap;
    logic               timed_out;
    logic               delta_pos;
    logic               sign_clash;
    logic [ACC_W-1:0]   acc_base;
    logic [SUM_W-1:0]   acc_sum;
    logic [SUM_W-1:0]   acc_mag;
    logic [ACC_W-1:0]   acc_new;
    logic [LINES_W-1:0] lines_low;

    t_unit_ctl         unit_ctl;
    t_unit_sts         unit_sts;
    logic [NUM_W-1:0]  unit_a;
    logic [RATE_W-1:0] unit_b;
    logic [NUM_W-1:0]  unit_result;

    wdla_serial_unit u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (unit_ctl),
        .i_operand (unit_a),
        .i_factor  (unit_b),
        .o_sts     (unit_sts),
        .o_result  (unit_result)
    );

    always_comb begin
        page_eff   = (r_page == '0) ? PAGE_W'(1) : r_page;
        reg_rate   = r_ax ? r_lines_v : r_chars_h;
        rate       = ((r_ax && r_page_mode) || ({2'b00, reg_rate} >= page_eff))
                     ? page_eff : {2'b00, reg_rate};
        win_change = (r_win != r_prev_win);
        acc_old    = r_acc[r_ax];
        idle_gap   = r_time - r_last[r_ax];
        timed_out  = (idle_gap > r_timeout);
        delta_pos  = !r_delta[DELTA_W-1] && (r_delta != '0);
        sign_clash = (delta_pos == acc_old[ACC_W-1]);
        acc_base   = (win_change || timed_out || sign_clash) ? '0 : acc_old;
        acc_sum    = {acc_base[ACC_W-1], acc_base}
                   + {{(SUM_W-DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
        acc_mag    = acc_sum[SUM_W-1] ? (~acc_sum + SUM_W'(1)) : acc_sum;
        // carried remainder takes the sign of the accumulated delta
        acc_new    = r_neg ? ACC_W'(~r_rem + SUM_W'(1)) : ACC_W'(r_rem);
        lines_low  = r_lines[LINES_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_lines_v   = r_lines_v;
        n_chars_h   = r_chars_h;
        n_page_mode = r_page_mode;
        n_timeout   = r_timeout;
        n_prev_win  = r_prev_win;
        n_last      = r_last;
        n_acc       = r_acc;
        n_win       = r_win;
        n_delta     = r_delta;
        n_page      = r_page;
        n_ax        = r_ax;
        n_time      = r_time;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_rate      = r_rate;
        n_lines     = r_lines;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_out_lines = r_out_lines;
        unit_ctl    = '{start: 1'b0, op: OP_MUL};
        unit_a      = unit_result;
        unit_b      = RATE_W'(NOTCH_UNITS);
        o_req_ready = 1'b0;

        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LINES_VERT:   n_lines_v   = i_cfg_data[NOTCH_W-1:0];
                CFG_CHARS_HORIZ:  n_chars_h   = i_cfg_data[NOTCH_W-1:0];
                CFG_PAGE_MODE:    n_page_mode = i_cfg_data[0];
                CFG_IDLE_TIMEOUT: n_timeout   = i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_win   = i_window_id;
                    n_delta = i_wheel_delta;
                    n_page  = i_page_size;
                    n_ax    = i_axis_vertical;
                    n_time  = i_time_ms;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_prev_win   = r_win;
                n_last[r_ax] = r_time;
                if (win_change) begin
                    n_acc[0] = '0;
                    n_acc[1] = '0;
                end
                n_mag  = acc_mag;
                n_neg  = acc_sum[SUM_W-1];
                n_rate = rate;
                if (rate == '0) begin
                    // no rate: no lines, drop the accumulator
                    n_lines = '0;
                    n_rem   = '0;
                    n_state = ST_FINISH;
                end else begin
                    unit_ctl = '{start: 1'b1, op: OP_MUL};
                    unit_a   = NUM_W'(acc_mag);
                    unit_b   = rate;
                    n_state  = ST_MUL_RATE;
                end
            end
            ST_MUL_RATE: begin
                if (unit_sts.done) begin
                    unit_ctl = '{start: 1'b1, op: OP_DIV};
                    n_state  = ST_DIV_NOTCH;
                end
            end
            ST_DIV_NOTCH: begin
                if (unit_sts.done) begin
                    n_lines  = unit_result[LINE_MAG_W-1:0];
                    unit_ctl = '{start: 1'b1, op: OP_MUL};
                    n_state  = ST_MUL_NOTCH;
                end
            end
            ST_MUL_NOTCH: begin
                if (unit_sts.done) begin
                    unit_ctl = '{start: 1'b1, op: OP_DIV};
                    unit_b   = r_rate;
                    n_state  = ST_DIV_RATE;
                end
            end
            ST_DIV_RATE: begin
                if (unit_sts.done) begin
                    n_rem   = r_mag - unit_result[SUM_W-1:0];
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output slot is free
                if (!r_out_valid || i_res_ready) begin
                    n_acc[r_ax] = acc_new;
                    n_out_valid = 1'b1;
                    n_out_lines = (r_neg ^ r_ax) ? (~lines_low + LINES_W'(1)) : lines_low;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lines_v   <= RST_LINES_VERT;
            r_chars_h   <= RST_CHARS_HORIZ;
            r_page_mode <= 1'b0;
            r_timeout   <= RST_IDLE_TIMEOUT;
            r_prev_win  <= '0;
            r_last[0]   <= '0;
            r_last[1]   <= '0;
            r_acc[0]    <= '0;
            r_acc[1]    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lines_v   <= n_lines_v;
            r_chars_h   <= n_chars_h;
            r_page_mode <= n_page_mode;
            r_timeout   <= n_timeout;
            r_prev_win  <= n_prev_win;
            r_last      <= n_last;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win       <= n_win;
        r_delta     <= n_delta;
        r_page      <= n_page;
        r_ax        <= n_ax;
        r_time      <= n_time;
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_rate      <= n_rate;
        r_lines     <= n_lines;
        r_rem       <= n_rem;
        r_out_lines <= n_out_lines;
    end

    assign o_res_valid    = r_out_valid;
    assign o_scroll_lines = r_out_lines;

endmodule

### rtl/wdla_checker.sv
// Port-level checks for the wheel delta line accumulator core, bound to
// the top level. Depends on wdla_pkg and wheel_delta_line_accumulator_core.
module wdla_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_req_valid,
    input logic                                o_req_ready,
    input logic                                o_res_valid,
    input logic                                i_res_ready,
    input logic signed [wdla_pkg::LINES_W-1:0] o_scroll_lines
);

    // reset leaves the core idle with no result pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_req_ready && !o_res_valid))
        else $error("core not idle after reset");

    // one request at a time: ready drops once a request is taken
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted while busy");

    // a result needs the setup state to pass before it can appear
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !$rose(o_res_valid))
        else $error("result appeared too early");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_scroll_lines)))
        else $error("stalled result changed");

endmodule

bind wheel_delta_line_accumulator_core wdla_checker u_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for wheel_delta_line_accumulator_core: drives wheel
// events over the request channel and checks every scroll result against a
// behavioural predictor. Depends on wdla_pkg and the core RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wdla_pkg::*;

    localparam int unsigned HALF_PERIOD    = 5;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned RUN_LIMIT      = 1_000_000;
    localparam int unsigned DRAIN_CYCLES   = 130;
    localparam int unsigned LONG_HOLD      = 600;
    localparam int unsigned HOLD_AT_RESULT = 300;
    // index outside the register map, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(6);

    typedef struct {
        logic [WIN_W-1:0]          window;
        logic signed [DELTA_W-1:0] delta;
        logic [PAGE_W-1:0]         page;
        logic                      vertical;
        logic [TIME_W-1:0]         stamp;
    } t_wheel_event;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data      = '0;
    logic                      i_req_valid     = 1'b0;
    logic                      o_req_ready;
    logic [WIN_W-1:0]          i_window_id     = '0;
    logic signed [DELTA_W-1:0] i_wheel_delta   = '0;
    logic [PAGE_W-1:0]         i_page_size     = '0;
    logic                      i_axis_vertical = 1'b0;
    logic [TIME_W-1:0]         i_time_ms       = '0;
    logic                      o_res_valid;
    logic                      i_res_ready     = 1'b0;
    logic signed [LINES_W-1:0] o_scroll_lines;

    wheel_delta_line_accumulator_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_window_id    (i_window_id),
        .i_wheel_delta  (i_wheel_delta),
        .i_page_size    (i_page_size),
        .i_axis_vertical(i_axis_vertical),
        .i_time_ms      (i_time_ms),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_scroll_lines (o_scroll_lines)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // predictor copy of registers and axis state
    logic [NOTCH_W-1:0] lines_vert_q  = RST_LINES_VERT;
    logic [NOTCH_W-1:0] chars_horiz_q = RST_CHARS_HORIZ;
    logic               page_mode_q   = 1'b0;
    logic [TIME_W-1:0]  idle_limit_q  = RST_IDLE_TIMEOUT;
    logic [WIN_W-1:0]   last_window   = '0;
    logic [TIME_W-1:0]  last_stamp [2] = '{'0, '0};
    int                 carry [2]      = '{0, 0};

    t_wheel_event              wheel_events [$];
    logic signed [LINES_W-1:0] scroll_due [$];

    int unsigned cycle_count  = 0;
    int unsigned error_count  = 0;
    int unsigned results_seen = 0;
    bit          req_fire     = 1'b0;
    bit          calm         = 1'b0;

    // generator state for well-formed scroll gestures
    logic [WIN_W-1:0]  gen_window = '0;
    logic [TIME_W-1:0] gen_stamp  = '0;
    bit                gen_down   = 1'b0;

    function automatic logic signed [LINES_W-1:0] accumulate_wheel(t_wheel_event ev);
        int unsigned       page;
        int unsigned       rate;
        int                side;
        longint            sum;
        longint            lines;
        logic [TIME_W-1:0] idle;
        page = (ev.page == '0) ? 1 : ev.page;
        side = int'(ev.vertical);
        rate = ev.vertical ? lines_vert_q : chars_horiz_q;
        if ((ev.vertical && page_mode_q) || rate >= page) begin
            rate = page;
        end
        idle = ev.stamp - last_stamp[side];
        if (ev.window != last_window) begin
            last_window = ev.window;
            carry[0]    = 0;
            carry[1]    = 0;
        end else if (idle > idle_limit_q || ((ev.delta > 0) == (carry[side] < 0))) begin
            carry[side] = 0;
        end
        if (rate != 0) begin
            sum   = longint'(carry[side]) + longint'(ev.delta);
            lines = (sum * longint'(rate)) / longint'(NOTCH_UNITS);
            sum   = sum - (lines * longint'(NOTCH_UNITS)) / longint'(rate);
            carry[side] = int'(sum);
        end else begin
            lines       = 0;
            carry[side] = 0;
        end
        last_stamp[side] = ev.stamp;
        return LINES_W'(ev.vertical ? -lines : lines);
    endfunction

    task automatic push_event(logic [WIN_W-1:0] window, int delta, int page,
                              logic vertical, logic [TIME_W-1:0] stamp);
        t_wheel_event ev;
        ev.window   = window;
        ev.delta    = DELTA_W'(delta);
        ev.page     = PAGE_W'(page);
        ev.vertical = vertical;
        ev.stamp    = stamp;
        wheel_events.push_back(ev);
    endtask

    task automatic queue_random_events(int unsigned count);
        t_wheel_event ev;
        int unsigned  roll;
        int           step;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                gen_window = WIN_W'($urandom);
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                gen_stamp = $urandom;
            end else if (roll < 20) begin
                gen_stamp = gen_stamp + $urandom_range(0, 2000);
            end else begin
                gen_stamp = gen_stamp + $urandom_range(0, 60);
            end
            ev.window   = gen_window;
            ev.stamp    = gen_stamp;
            ev.vertical = 1'($urandom_range(0, 1));
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                ev.delta = DELTA_W'($urandom);
            end else if (roll < 15) begin
                ev.delta = '0;
            end else begin
                // keep scrolling one way most of the time
                if ($urandom_range(0, 9) == 0) begin
                    gen_down = ~gen_down;
                end
                step = ($urandom_range(0, 2) == 0) ? 120 * $urandom_range(1, 4)
                                                   : $urandom_range(1, 119);
                ev.delta = DELTA_W'(gen_down ? -step : step);
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                ev.page = PAGE_W'($urandom);
            end else if (roll < 15) begin
                ev.page = '0;
            end else begin
                ev.page = PAGE_W'($urandom_range(1, 40));
            end
            wheel_events.push_back(ev);
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_LINES_VERT:   lines_vert_q  = value[NOTCH_W-1:0];
            CFG_CHARS_HORIZ:  chars_horiz_q = value[NOTCH_W-1:0];
            CFG_PAGE_MODE:    page_mode_q   = value[0];
            CFG_IDLE_TIMEOUT: idle_limit_q  = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(int unsigned lines, int unsigned chars, bit page_mode,
                                  logic [TIME_W-1:0] idle_limit);
        write_register(CFG_LINES_VERT, lines);
        write_register(CFG_CHARS_HORIZ, chars);
        write_register(CFG_PAGE_MODE, CFG_DATA_W'(page_mode));
        write_register(CFG_IDLE_TIMEOUT, idle_limit);
        write_register(CFG_SPARE_IDX, $urandom);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (wheel_events.size() != 0 || i_req_valid || scroll_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_wheel_event              seen;
        logic signed [LINES_W-1:0] want;
        req_fire = i_rst_n && i_req_valid && o_req_ready;
        if (req_fire) begin
            seen.window   = i_window_id;
            seen.delta    = i_wheel_delta;
            seen.page     = i_page_size;
            seen.vertical = i_axis_vertical;
            seen.stamp    = i_time_ms;
            scroll_due.push_back(accumulate_wheel(seen));
        end
        if (i_rst_n && o_res_valid && i_res_ready) begin
            results_seen++;
            if (scroll_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d",
                         $time, o_scroll_lines);
                error_count++;
            end else begin
                want = scroll_due.pop_front();
                if (want !== o_scroll_lines) begin
                    $display("%0t: scroll_lines mismatch, expected %0d, got %0d",
                             $time, want, o_scroll_lines);
                    error_count++;
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_wheel_event       ev;
        static int unsigned gap_left   = 0;
        static bit          send_quiet = 1'b0;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (!i_req_valid || req_fire) begin
            if ($urandom_range(0, 29) == 0) begin
                send_quiet = ~send_quiet;
            end
            if (gap_left > 0) begin
                gap_left--;
                i_req_valid <= 1'b0;
            end else if (wheel_events.size() != 0) begin
                if (!calm && !send_quiet && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    i_req_valid <= 1'b0;
                end else begin
                    ev = wheel_events.pop_front();
                    i_window_id     <= ev.window;
                    i_wheel_delta   <= ev.delta;
                    i_page_size     <= ev.page;
                    i_axis_vertical <= ev.vertical;
                    i_time_ms       <= ev.stamp;
                    i_req_valid     <= 1'b1;
                end
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // result receiver: short random stalls plus one long hold to back the core up
    always @(negedge i_clk) begin
        static int unsigned stall_left     = 0;
        static int unsigned long_hold_left = 0;
        static bit          long_hold_done = 1'b0;
        static bit          res_quiet      = 1'b0;
        if (!long_hold_done && results_seen >= HOLD_AT_RESULT) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD;
        end
        if ($urandom_range(0, 199) == 0) begin
            res_quiet = ~res_quiet;
        end
        if (long_hold_left > 0) begin
            long_hold_left--;
            i_res_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_res_ready <= 1'b0;
        end else if (!calm && !res_quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults; window 0 matches the cleared window id
        push_event(16'h0000, 120, 10, 1'b1, 100);
        // partial notches of 40 scroll one char each, then 20 is carried
        push_event(16'h0000, 40, 10, 1'b0, 110);
        push_event(16'h0000, 40, 10, 1'b0, 120);
        push_event(16'h0000, 40, 10, 1'b0, 130);
        push_event(16'h0000, 20, 10, 1'b0, 140);
        // zero delta: drops a positive carry, holds a negative one
        push_event(16'h0000, 0, 10, 1'b0, 150);
        push_event(16'h0000, -20, 10, 1'b0, 160);
        push_event(16'h0000, 0, 10, 1'b0, 170);
        push_event(16'h0000, 60, 10, 1'b0, 180);
        // delta extremes, page extremes, page 0 taken as 1
        push_event(16'h0000, 32767, 1023, 1'b1, 200);
        push_event(16'h0000, -32768, 1023, 1'b1, 210);
        push_event(16'h0000, -32768, 0, 1'b1, 220);
        push_event(16'h0000, 32767, 1, 1'b0, 230);
        // window change, rate capped by a small page
        push_event(16'hFFFF, 120, 2, 1'b0, 240);
        push_event(16'hFFFF, 30, 5, 1'b1, 241);
        // idle just past the timeout, then exactly at it
        push_event(16'hFFFF, 30, 5, 1'b1, 1242);
        push_event(16'hFFFF, 30, 5, 1'b1, 2242);
        // timestamp wraparound
        push_event(16'hFFFF, 30, 5, 1'b0, 32'hFFFF_FFF0);
        push_event(16'hFFFF, 90, 5, 1'b0, 32'h0000_0010);
        push_event(16'h5A5A, -120, 1023, 1'b0, 32'hAAAA_AAAA);
        push_event(16'hA5A5, -360, 1023, 1'b1, 32'h5555_5555);
        push_event(16'hA5A5, -1, 1023, 1'b1, 32'h5555_5556);
        wait_until_drained();

        apply_settings(3, 3, 1'b0, 1000);
        queue_random_events(150);
        wait_until_drained();

        apply_settings(255, 255, 1'b0, 32'hFFFF_FFFF);
        queue_random_events(150);
        wait_until_drained();

        // zero rates; vertical page mode still scrolls by page
        apply_settings(0, 0, 1'b1, 0);
        queue_random_events(100);
        wait_until_drained();

        // page mode must not touch the horizontal axis
        apply_settings(1, 200, 1'b1, 500);
        queue_random_events(150);
        wait_until_drained();

        apply_settings(7, 0, 1'b0, 50);
        queue_random_events(150);
        wait_until_drained();

        apply_settings($urandom_range(0, 255), $urandom_range(0, 255),
                       1'($urandom_range(0, 1)), $urandom_range(0, 3000));
        queue_random_events(200);
        wait_until_drained();

        // final stretch runs at full rate on both sides
        calm = 1'b1;
        apply_settings(3, 3, 1'b0, 1000);
        queue_random_events(130);
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && scroll_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/wdla_pkg.sv
rtl/wdla_serial_unit.sv
rtl/wheel_delta_line_accumulator_core.sv
rtl/wdla_checker.sv
tb/tb_top.sv
